### rtl/core/msq_pkg.sv
// Shared types and constants for the maximal all-ones square scanner.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package msq_pkg;

   // Fixed field widths of the external interface.
   localparam int SIDE_W    = 11;
   localparam int IDX_W     = 10;
   localparam int LEN_REG_W = 11;

   // Row length register value after reset.
   localparam logic [LEN_REG_W-1:0] ROW_LENGTH_RESET = 11'd1024;

   // Defaults for the geometry parameters of the top level.
   localparam int MAX_COLUMNS_DEFAULT = 1024;
   localparam int MAX_ROWS_DEFAULT    = 1024;

   // Depth of the small queues between the parts of the block.
   localparam int QUEUE_DEPTH = 2;

   // Classification of one cell, made by the front end for the back end.
   typedef struct packed {
      logic cell_value;  // the cell itself
      logic last_cell;   // final cell of the matrix
      logic border;      // first row or first column: side equals the cell
      logic top_row;     // first row: there is no row above
      logic row_end;     // the scan wraps to the next row after this cell
   } cell_class_type;

endpackage : msq_pkg

`default_nettype wire

### rtl/core/max_square_of_ones_scan_unit.sv
// Top level of the maximal all-ones square scanner: front end, cell queue, back end
// and result queue. Depends on msq_pkg, msq_fifo, msq_front and msq_back.
`default_nettype none

// Channel    Direction  Handshake                 Payload
// req_       in         req_push / req_full       req_cell_value, req_last_cell
// rsp_       out        rsp_empty / rsp_pop       rsp_square_side, rsp_bottom_row,
//                                                 rsp_right_column
// csr_       in         csr_wr_en                 csr_wr_data (row length)
//
// The block takes one cell transaction per clock cycle, sustained, with no gaps at
// row ends or between matrices, unless a last cell waits on a full result queue.
// Each result goes from the back end into the result queue, read on the rsp_ ports.
// The line buffer is read as a cell enters the back end and written as it leaves.
// Reset clears the scan position, the neighbor and best-square registers and both
// queues, and loads a row length of 1024. The line buffer needs no clearing pass.
// When results are not popped, the result queue fills, the back end holds the last
// cell, the cell queue fills and req_full rises; ordinary cells keep draining until
// a last cell meets a full result queue.

module max_square_of_ones_scan_unit
   import msq_pkg::*;
#(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT,
   parameter int MAX_ROWS    = MAX_ROWS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic                 req_cell_value,
   input  wire logic                 req_last_cell,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [SIDE_W-1:0]         rsp_square_side,
   output logic [IDX_W-1:0]          rsp_bottom_row,
   output logic [IDX_W-1:0]          rsp_right_column,
   input  wire logic                 csr_wr_en,
   input  wire logic [LEN_REG_W-1:0] csr_wr_data
);

   localparam int ColW   = $clog2(MAX_COLUMNS);
   localparam int RowW   = $clog2(MAX_ROWS);
   localparam int ClassW = $bits(cell_class_type);
   localparam int CellW  = ClassW + ColW + RowW;
   localparam int RespW  = SIDE_W + 2 * IDX_W;

   // Front end to cell queue.
   logic                 cq_push;
   logic                 cq_full;
   cell_class_type       fe_class;
   logic [ColW-1:0]      fe_col;
   logic [RowW-1:0]      fe_row;
   logic [CellW-1:0]     cq_push_data;

   // Cell queue to back end.
   logic                 cq_pop;
   logic                 cq_empty;
   logic [CellW-1:0]     cq_pop_data;
   cell_class_type       be_class;
   logic [ColW-1:0]      be_col;
   logic [RowW-1:0]      be_row;

   // Back end to result queue.
   logic                 rq_push;
   logic                 rq_full;
   logic [SIDE_W-1:0]    be_side;
   logic [IDX_W-1:0]     be_row_out;
   logic [IDX_W-1:0]     be_col_out;
   logic [RespW-1:0]     rq_pop_data;

   msq_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .COL_W       (ColW),
      .ROW_W       (RowW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cell_push   (req_push),
      .cell_value  (req_cell_value),
      .last_cell   (req_last_cell),
      .queue_full  (cq_full),
      .queue_push  (cq_push),
      .queue_class (fe_class),
      .queue_col   (fe_col),
      .queue_row   (fe_row)
   );

   assign req_full     = cq_full;
   assign cq_push_data = {fe_class, fe_col, fe_row};

   // The cell queue lets the front end keep taking cells while the back end
   // waits on the result side.
   msq_fifo #(
      .WIDTH (CellW),
      .DEPTH (QUEUE_DEPTH)
   ) u_cell_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cq_push),
      .push_data (cq_push_data),
      .full      (cq_full),
      .pop       (cq_pop),
      .pop_data  (cq_pop_data),
      .empty     (cq_empty)
   );

   assign be_class = cell_class_type'(cq_pop_data[CellW-1 -: ClassW]);
   assign be_col   = cq_pop_data[RowW +: ColW];
   assign be_row   = cq_pop_data[RowW-1:0];

   msq_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .COL_W       (ColW),
      .ROW_W       (RowW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (!cq_empty),
      .in_class (be_class),
      .in_col   (be_col),
      .in_row   (be_row),
      .in_pop   (cq_pop),
      .out_full (rq_full),
      .out_push (rq_push),
      .out_side (be_side),
      .out_row  (be_row_out),
      .out_col  (be_col_out)
   );

   // The result queue parts the back end from the consumer of the rsp_ channel.
   msq_fifo #(
      .WIDTH (RespW),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data ({be_side, be_row_out, be_col_out}),
      .full      (rq_full),
      .pop       (rsp_pop),
      .pop_data  (rq_pop_data),
      .empty     (rsp_empty)
   );

   assign rsp_square_side  = rq_pop_data[RespW-1 -: SIDE_W];
   assign rsp_bottom_row   = rq_pop_data[IDX_W +: IDX_W];
   assign rsp_right_column = rq_pop_data[IDX_W-1:0];

   // The back end only hands over a result when the result queue has room.
   a_result_not_lost : assert property (@(posedge clock) disable iff (reset)
      !(rq_push && rq_full))
      else $error("result pushed into a full result queue");

   // The back end only takes a cell that the cell queue actually holds.
   a_cell_pop_valid : assert property (@(posedge clock) disable iff (reset)
      !(cq_pop && cq_empty))
      else $error("back end took a cell from an empty queue");

   // The cell queue never reports full and empty at the same time.
   a_cell_queue_flags : assert property (@(posedge clock) disable iff (reset)
      !(cq_full && cq_empty))
      else $error("cell queue is full and empty at once");

endmodule : max_square_of_ones_scan_unit

`default_nettype wire

### rtl/core/msq_fifo.sv
// Small first-in first-out queue used between the parts of the scanner.
// Depends on msq_pkg for the default depth.
`default_nettype none

module msq_fifo
   import msq_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule : msq_fifo

`default_nettype wire

### rtl/core/msq_front.sv
// Front end of the scanner: row length register, scan position and cell classification.
// Depends on msq_pkg.
`default_nettype none

module msq_front
   import msq_pkg::*;
#(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT,
   parameter int MAX_ROWS    = MAX_ROWS_DEFAULT,
   parameter int COL_W       = $clog2(MAX_COLUMNS),
   parameter int ROW_W       = $clog2(MAX_ROWS)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [LEN_REG_W-1:0] csr_wr_data,
   input  wire logic                 cell_push,
   input  wire logic                 cell_value,
   input  wire logic                 last_cell,
   input  wire logic                 queue_full,
   output logic                      queue_push,
   output cell_class_type            queue_class,
   output logic [COL_W-1:0]          queue_col,
   output logic [ROW_W-1:0]          queue_row
);

   localparam int LenW = $clog2(MAX_COLUMNS + 1);

   logic [LEN_REG_W-1:0] row_length_ff;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [LenW-1:0]      eff_length;
   logic                 accept;
   logic                 row_end;

   // A zero length counts as one; anything beyond the line buffer saturates.
   always_comb begin
      if (row_length_ff == '0) begin
         eff_length = LenW'(1);
      end else if (32'(row_length_ff) > 32'(MAX_COLUMNS)) begin
         eff_length = LenW'(MAX_COLUMNS);
      end else begin
         eff_length = LenW'(row_length_ff);
      end
   end

   assign accept  = cell_push && !queue_full;
   assign row_end = (LenW'(col_ff) + LenW'(1)) >= eff_length;

   assign queue_push             = accept;
   assign queue_col              = col_ff;
   assign queue_row              = row_ff;
   assign queue_class.cell_value = cell_value;
   assign queue_class.last_cell  = last_cell;
   assign queue_class.border     = (row_ff == '0) || (col_ff == '0);
   assign queue_class.top_row    = (row_ff == '0);
   assign queue_class.row_end    = row_end;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         priority if (last_cell) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            if (row_ff != ROW_W'(MAX_ROWS - 1)) begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            row_length_ff <= csr_wr_data;
         end
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule : msq_front

`default_nettype wire

### rtl/core/msq_back.sv
// Back end of the scanner: line buffer, square side update and best-square tracking.
// Depends on msq_pkg.
`default_nettype none

module msq_back
   import msq_pkg::*;
#(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT,
   parameter int MAX_ROWS    = MAX_ROWS_DEFAULT,
   parameter int COL_W       = $clog2(MAX_COLUMNS),
   parameter int ROW_W       = $clog2(MAX_ROWS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire cell_class_type    in_class,
   input  wire logic [COL_W-1:0]  in_col,
   input  wire logic [ROW_W-1:0]  in_row,
   output logic                   in_pop,
   input  wire logic              out_full,
   output logic                   out_push,
   output logic [SIDE_W-1:0]      out_side,
   output logic [IDX_W-1:0]       out_row,
   output logic [IDX_W-1:0]       out_col
);

   logic [SIDE_W-1:0] line_buf [MAX_COLUMNS];

   logic              valid_ff, valid_in;
   cell_class_type    class_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [SIDE_W-1:0] up_rd_ff;

   logic [SIDE_W-1:0] left_ff, left_in;
   logic [SIDE_W-1:0] diag_ff, diag_in;
   logic [SIDE_W-1:0] best_side_ff, best_side_in;
   logic [ROW_W-1:0]  best_row_ff, best_row_in;
   logic [COL_W-1:0]  best_col_ff, best_col_in;

   logic              fire;
   logic              advance;
   logic [SIDE_W-1:0] up;
   logic [SIDE_W-1:0] min_ul;
   logic [SIDE_W-1:0] min_all;
   logic [SIDE_W-1:0] side;
   logic [31:0]       row_wide;
   logic [31:0]       col_wide;

   // A cell waits in the stage only when it must hand over a result and cannot.
   assign fire    = valid_ff && !(class_ff.last_cell && out_full);
   assign advance = in_valid && (!valid_ff || fire);
   assign in_pop  = advance;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   assign up      = class_ff.top_row ? '0 : up_rd_ff;
   assign min_ul  = (up < left_ff) ? up : left_ff;
   assign min_all = (min_ul < diag_ff) ? min_ul : diag_ff;

   always_comb begin
      priority if (class_ff.border) begin
         side = SIDE_W'(class_ff.cell_value);
      end else if (class_ff.cell_value) begin
         side = min_all + SIDE_W'(1);
      end else begin
         side = '0;
      end
   end

   always_comb begin
      best_side_in = best_side_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      if (side > best_side_ff) begin
         best_side_in = side;
         best_row_in  = row_ff;
         best_col_in  = col_ff;
      end
      left_in = class_ff.row_end ? '0 : side;
      diag_in = class_ff.row_end ? '0 : up;
   end

   assign row_wide = 32'(best_row_in);
   assign col_wide = 32'(best_col_in);
   assign out_push = fire && class_ff.last_cell;
   assign out_side = best_side_in;
   assign out_row  = row_wide[IDX_W-1:0];
   assign out_col  = col_wide[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         left_ff      <= '0;
         diag_ff      <= '0;
         best_side_ff <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         if (fire) begin
            if (class_ff.last_cell) begin
               left_ff      <= '0;
               diag_ff      <= '0;
               best_side_ff <= '0;
               best_row_ff  <= '0;
               best_col_ff  <= '0;
            end else begin
               left_ff      <= left_in;
               diag_ff      <= diag_in;
               best_side_ff <= best_side_in;
               best_row_ff  <= best_row_in;
               best_col_ff  <= best_col_in;
            end
         end
      end
   end

   // Stage payload and the line buffer read both move with the cell.
   always_ff @(posedge clock) begin
      if (advance) begin
         class_ff <= in_class;
         col_ff   <= in_col;
         row_ff   <= in_row;
         up_rd_ff <= line_buf[in_col];
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         line_buf[col_ff] <= side;
      end
   end

endmodule : msq_back

`default_nettype wire

### tb/sv/msq_scan_checker.sv
// Scoreboard for the maximal all-ones square scanner: watches the cell, result and
// row-length ports, predicts each square result and compares it. Depends on msq_pkg.
module msq_scan_checker
   import msq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire logic                 req_full,
   input  wire logic                 req_cell_value,
   input  wire logic                 req_last_cell,
   input  wire logic                 rsp_empty,
   input  wire logic                 rsp_pop,
   input  wire logic [SIDE_W-1:0]    rsp_square_side,
   input  wire logic [IDX_W-1:0]     rsp_bottom_row,
   input  wire logic [IDX_W-1:0]     rsp_right_column,
   input  wire logic                 csr_wr_en,
   input  wire logic [LEN_REG_W-1:0] csr_wr_data,
   output int                        squares_awaited,
   output int                        mismatch_count
);

   localparam int COLUMNS = MAX_COLUMNS_DEFAULT;
   localparam int ROWS    = MAX_ROWS_DEFAULT;

   typedef struct packed {
      logic [SIDE_W-1:0] side;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  column;
   } square_result_type;

   logic [LEN_REG_W-1:0] row_length;
   logic [SIDE_W-1:0]    line_sides [COLUMNS];
   logic [SIDE_W-1:0]    left_side;
   logic [SIDE_W-1:0]    diag_side;
   logic [SIDE_W-1:0]    best_side;
   logic [IDX_W-1:0]     best_row;
   logic [IDX_W-1:0]     best_column;
   int                   scan_column;
   int                   scan_row;
   int                   errors;
   square_result_type    awaited_squares [$];

   function automatic int scan_width();
      if (row_length == '0) begin
         return 1;
      end
      if (int'(row_length) > COLUMNS) begin
         return COLUMNS;
      end
      return int'(row_length);
   endfunction

   task automatic restart_matrix();
      left_side   = '0;
      diag_side   = '0;
      scan_column = 0;
      scan_row    = 0;
      best_side   = '0;
      best_row    = '0;
      best_column = '0;
   endtask

   task automatic report_mismatch(input string detail);
      errors++;
      $display("[%0t] square result mismatch: %s", $time, detail);
   endtask

   // One cell of the scan: local square side, running best, line buffer and position.
   task automatic advance_square_scan(input logic cell_bit, input logic last);
      int                width;
      logic [SIDE_W-1:0] above;
      logic [SIDE_W-1:0] side;
      logic [SIDE_W-1:0] lowest;
      square_result_type entry;
      width = scan_width();
      above = (scan_row != 0) ? line_sides[scan_column] : '0;
      if (scan_row == 0 || scan_column == 0) begin
         side = SIDE_W'(cell_bit);
      end else if (cell_bit) begin
         lowest = (above < left_side) ? above : left_side;
         if (diag_side < lowest) begin
            lowest = diag_side;
         end
         side = lowest + SIDE_W'(1);
      end else begin
         side = '0;
      end
      // Strictly greater, so the earliest cell wins a tie.
      if (side > best_side) begin
         best_side   = side;
         best_row    = IDX_W'(scan_row);
         best_column = IDX_W'(scan_column);
      end
      line_sides[scan_column] = side;
      diag_side = above;
      left_side = side;
      if (scan_column + 1 >= width) begin
         scan_column = 0;
         left_side   = '0;
         diag_side   = '0;
         if (scan_row < ROWS - 1) begin
            scan_row++;
         end
      end else begin
         scan_column++;
      end
      if (last) begin
         entry.side   = best_side;
         entry.row    = best_row;
         entry.column = best_column;
         awaited_squares.push_back(entry);
         restart_matrix();
      end
   endtask

   always @(posedge clock) begin : watch
      square_result_type seen;
      square_result_type want;
      if (reset) begin
         row_length = ROW_LENGTH_RESET;
         awaited_squares.delete();
         restart_matrix();
      end else begin
         if (!rsp_empty && rsp_pop) begin
            seen.side   = rsp_square_side;
            seen.row    = rsp_bottom_row;
            seen.column = rsp_right_column;
            if (awaited_squares.size() == 0) begin
               report_mismatch($sformatf("unexpected result side %0d row %0d column %0d",
                                         seen.side, seen.row, seen.column));
            end else begin
               want = awaited_squares.pop_front();
               if (seen.side !== want.side || seen.row !== want.row ||
                   seen.column !== want.column) begin
                  report_mismatch($sformatf(
                     "side %0d exp %0d, row %0d exp %0d, column %0d exp %0d",
                     seen.side, want.side, seen.row, want.row, seen.column, want.column));
               end
            end
         end
         if (req_push && !req_full) begin
            advance_square_scan(req_cell_value, req_last_cell);
         end
         // A new length applies from the next cell on.
         if (csr_wr_en) begin
            row_length = csr_wr_data;
         end
      end
      squares_awaited <= awaited_squares.size();
      mismatch_count  <= errors;
   end

endmodule

### tb/sv/tb_max_square_of_ones_scan_unit.sv
// Top of the testbench for max_square_of_ones_scan_unit: clock, reset, cell and
// row-length stimulus, result popping and the verdict. Depends on msq_pkg and msq_scan_checker.
module tb_max_square_of_ones_scan_unit;
   import msq_pkg::*;

   localparam int CLOCK_HALF    = 2;
   localparam int RESET_CYCLES  = 11;
   // Margin after the last result is popped, before the verdict.
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_CELLS  = 540;
   localparam int MIN_MATRICES  = 16;
   // Upper bound on the length of the run, for the watchdog.
   localparam int LIMIT_CYCLES  = 1_000_000;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_push       = 1'b0;
   logic                 req_cell_value = 1'b0;
   logic                 req_last_cell  = 1'b0;
   logic                 rsp_pop        = 1'b0;
   logic                 csr_wr_en      = 1'b0;
   logic [LEN_REG_W-1:0] csr_wr_data    = '0;
   logic                 req_full;
   logic                 rsp_empty;
   logic [SIDE_W-1:0]    rsp_square_side;
   logic [IDX_W-1:0]     rsp_bottom_row;
   logic [IDX_W-1:0]     rsp_right_column;
   int                   squares_awaited;
   int                   mismatch_count;

   // Idling control. sender_gaps switches the sender's pauses per phase; calm turns
   // off idling on both sides for the closing stretch of the run.
   bit sender_gaps = 1'b1;
   bit calm        = 1'b0;
   int cells_sent  = 0;
   int matrices_sent = 0;

   always #CLOCK_HALF clock = ~clock;

   max_square_of_ones_scan_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_cell_value   (req_cell_value),
      .req_last_cell    (req_last_cell),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_square_side  (rsp_square_side),
      .rsp_bottom_row   (rsp_bottom_row),
      .rsp_right_column (rsp_right_column),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   msq_scan_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_cell_value   (req_cell_value),
      .req_last_cell    (req_last_cell),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_square_side  (rsp_square_side),
      .rsp_bottom_row   (rsp_bottom_row),
      .rsp_right_column (rsp_right_column),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .squares_awaited  (squares_awaited),
      .mismatch_count   (mismatch_count)
   );

   // Offers one cell transaction and holds it until the block takes it. Push stays
   // high into the next call unless a pause is drawn, so back-to-back cells never
   // lower and raise the push in the same step.
   task automatic push_cell(input logic value, input logic last);
      int gap;
      req_push       <= 1'b1;
      req_cell_value <= value;
      req_last_cell  <= last;
      do @(posedge clock); while (req_full !== 1'b0);
      cells_sent++;
      if (last) begin
         matrices_sent++;
      end
      if (!calm && sender_gaps && $urandom_range(0, 11) == 0) begin
         gap = $urandom_range(1, 15);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sends a pattern written as a string of '0' and '1' characters in scan order.
   // When close is set, the final character carries the last-cell mark.
   task automatic send_text(input string bits, input bit close);
      for (int i = 0; i < bits.len(); i++) begin
         push_cell(bits[i] == "1", close && i == bits.len() - 1);
      end
   endtask

   task automatic send_fill(input int count, input logic value, input bit close);
      for (int i = 0; i < count; i++) begin
         push_cell(value, close && i == count - 1);
      end
   endtask

   // Stops sending and waits until every predicted square has been popped, then lets
   // the block settle. The short wait first lets the checker's count catch up with
   // the last cell.
   task automatic await_idle();
      if (req_push) begin
         req_push <= 1'b0;
      end
      repeat (2) @(posedge clock);
      while (squares_awaited != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The row length register is only written with the block idle.
   task automatic set_row_length(input logic [LEN_REG_W-1:0] length);
      await_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= length;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // A matrix of whole rows with random content at a random density of ones. Some
   // matrices are cut short mid-row, and long ones are cut to keep the run quick.
   task automatic send_random_matrix(input int width);
      int rows;
      int total;
      int density;
      rows  = $urandom_range(1, 6);
      total = rows * width;
      if (total > 80 || $urandom_range(0, 6) == 0) begin
         total = $urandom_range(1, (total > 80) ? 80 : total);
      end
      case ($urandom_range(0, 3))
         0: begin
            density = 15;
         end
         1: begin
            density = 50;
         end
         2: begin
            density = 85;
         end
         default: begin
            density = 100;
         end
      endcase
      for (int i = 0; i < total; i++) begin
         push_cell($urandom_range(0, 99) < density, i == total - 1);
      end
   endtask

   // The consumer pops at will but stalls in random bursts, except in the calm closing
   // stretch.
   initial begin : pop_pacing
      int hold;
      hold = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (calm) begin
            rsp_pop <= 1'b1;
         end else if (hold > 0) begin
            rsp_pop <= 1'b0;
            hold--;
         end else if ($urandom_range(0, 9) == 0) begin
            rsp_pop <= 1'b0;
            hold = $urandom_range(0, 14);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int start_cells;
      int start_matrices;
      int pick;
      int length;
      int width;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. First the reset length of 1024: a short matrix cut in row 0,
      // then a single zero cell, which must report all zeros.
      send_text("110", 1'b1);
      send_text("0", 1'b1);

      // A zero length acts as one column, so every cell is a border cell.
      set_row_length('0);
      send_text("0110", 1'b1);

      // Two equal 2x2 squares: the earlier one in scan order must be kept. Then a
      // matrix ended in the middle of its second row.
      set_row_length(LEN_REG_W'(5));
      send_text("110111101100100", 1'b1);
      send_text("1111111", 1'b1);

      // An all-ones length saturates to 1024 columns, so a short matrix stays in
      // row 0 and every cell is a border cell.
      set_row_length('1);
      send_text("0111", 1'b1);

      set_row_length(LEN_REG_W'(1024));
      send_text("1", 1'b1);

      // A solid 8x8 block.
      set_row_length(LEN_REG_W'(8));
      send_fill(8 * 8, 1'b1, 1'b1);

      set_row_length(LEN_REG_W'(1));
      send_text("1", 1'b1);

      // Random part: phases of a few matrices each, at a fresh row length. Most
      // lengths are small; a few are zero, the largest or past the largest.
      start_cells    = cells_sent;
      start_matrices = matrices_sent;
      while (cells_sent - start_cells < RANDOM_CELLS ||
             matrices_sent - start_matrices < MIN_MATRICES) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            length = $urandom_range(1, 12);
         end else if (pick < 17) begin
            length = $urandom_range(13, 64);
         end else if (pick == 17) begin
            length = 0;
         end else if (pick == 18) begin
            length = 1024;
         end else begin
            length = $urandom_range(1025, 2047);
         end
         width = (length == 0) ? 1 : ((length > 1024) ? 1024 : length);
         set_row_length(LEN_REG_W'(length));
         sender_gaps = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 6)) send_random_matrix(width);
      end

      // Closing stretch with no idling on either side.
      length = $urandom_range(2, 8);
      set_row_length(LEN_REG_W'(length));
      calm <= 1'b1;
      repeat (6) send_random_matrix(length);
      await_idle();

      if (mismatch_count == 0 && squares_awaited == 0) begin
         $display("PASS max_square_of_ones_scan_unit");
      end else begin
         $display("FAIL max_square_of_ones_scan_unit");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * 2 * CLOCK_HALF);
      $display("FAIL max_square_of_ones_scan_unit");
      $finish;
   end

endmodule
